FILE: rtl/acdm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// acdm_pkg
// Constants and the modulo-65521 reduction shared by the checksum block.
// ---------------------------------------------------------------------------
package acdm_pkg;

  // Checksum modulus and the half-word mask
  localparam logic [15:0] ADLER_MOD = 16'hfff1;
  localparam logic [15:0] HALF_MASK = 16'hffff;
  // 2^16 mod 65521
  localparam logic [4:0]  FOLD_MUL  = 5'd15;

  typedef logic [31:0] sum_t;

  // Reduce a 32-bit value modulo 65521: two folds of 2^16 == 15, then one
  // conditional subtract (the second fold stays below twice the modulus).
  function automatic logic [15:0] mod_adler(input sum_t x);
    logic [19:0] fold1;
    logic [16:0] fold2;
    logic [16:0] diff;
    fold1 = 20'(x[31:16]) * 20'(FOLD_MUL) + 20'(x[15:0]);
    fold2 = 17'(fold1[19:16]) * 17'(FOLD_MUL) + 17'(fold1[15:0]);
    diff  = fold2 - 17'(ADLER_MOD);
    if (fold2 >= 17'(ADLER_MOD)) begin
      return diff[15:0];
    end
    return fold2[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/adler_checksum_deferred_mod_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adler_checksum_deferred_mod_unit
// Streaming Adler-32 style checksum, one byte per cycle, deferred modulo.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data_byte / in_last_byte) takes
//   one message byte per transfer; in_last_byte marks the final byte.
//   Output channel (out_valid / out_stall / out_checksum) carries one
//   checksum per message, produced on its last byte.
//   cfg_wr_en / cfg_wr_data write the seed (previous checksum); a new seed
//   takes effect at the start of the next message. Write it while idle.
// Timing:
//   A byte is captured in an input register and folded into the sums as it
//   leaves; a last byte also loads the result register that presents the
//   checksum. Throughput is one byte per cycle while no last byte waits on
//   a stalled result, set by the single add/add/fold path for both sums.
// Reset and stall:
//   Reset loads the seed with 1 and arms the start of a new message.
//   While out_stall holds a checksum, bytes other than a last byte keep
//   flowing; a last byte waits in the input register, raising in_stall.
// ---------------------------------------------------------------------------
module adler_checksum_deferred_mod_unit
  import acdm_pkg::*;
#(
  parameter int REDUCE_INTERVAL = 5552
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_checksum
);

  localparam int POS_W = (REDUCE_INTERVAL > 1) ? $clog2(REDUCE_INTERVAL) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(REDUCE_INTERVAL - 1);

  logic [31:0]      seed_r;
  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;
  sum_t             low_r, low_nxt;
  sum_t             high_r, high_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             first_r, first_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_checksum_r;

  logic             in_xfer;
  logic             adv;
  logic             out_free;
  sum_t             base_low, base_high, low_add, high_add;
  logic [POS_W-1:0] pos_cur;
  logic             do_reduce;

  // Handshake: a last byte waits only for room in the result register
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  assign s1_valid_nxt = in_xfer ? 1'b1 : (adv ? 1'b0 : s1_valid_r);

  // Sum update: load seed at message start, add, reduce at block/message end
  always_comb begin
    base_low  = first_r ? {16'h0, seed_r[15:0] & HALF_MASK} : low_r;
    base_high = first_r ? {16'h0, seed_r[31:16] & HALF_MASK} : high_r;
    pos_cur   = first_r ? '0 : pos_r;
    low_add   = base_low + {24'h0, s1_byte_r};
    high_add  = base_high + low_add;
    do_reduce = !first_r && ((pos_cur == '0) || s1_last_r);
    low_nxt   = do_reduce ? {16'h0, mod_adler(low_add)} : low_add;
    high_nxt  = do_reduce ? {16'h0, mod_adler(high_add)} : high_add;
    pos_nxt   = (pos_cur == POS_LAST) ? '0 : pos_cur + POS_W'(1);
    first_nxt = s1_last_r;
  end

  // Result register: load on a last byte, drop once transferred
  assign out_valid_nxt = (adv && s1_last_r) ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= 32'h1;
      s1_valid_r  <= 1'b0;
      pos_r       <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        pos_r   <= pos_nxt;
        first_r <= first_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (adv) begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
    if (adv && s1_last_r) begin
      out_checksum_r <= {high_nxt[15:0], 16'h0} | low_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = out_checksum_r;

  // Assertions
  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_last_r |=> first_r)
    else $error("message start not armed after last byte");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("block position out of range");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv && s1_last_r))
    else $error("result raised without a last byte");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

endmodule
`default_nettype wire

FILE: test/acdm_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// acdm_checker
// Watches the byte and checksum channels of the deferred-modulo checksum
// block, keeps its own copy of the running sums and the seed, and compares
// every checksum transfer with the oldest predicted value.
// ---------------------------------------------------------------------------
module acdm_checker
  import acdm_pkg::*;
#(
  parameter int REDUCE_INTERVAL = 5552
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_checksum,
  output int          mismatch_count,
  output int          pending_count
);

  sum_t        seed_reg;
  sum_t        low_acc;
  sum_t        high_acc;
  logic [12:0] block_pos;
  bit          msg_start;
  sum_t        expected_sum;
  sum_t        checksum_q[$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  // Fold one byte into the running sums; queue a checksum on the last byte
  task automatic absorb_byte(input logic [7:0] data, input logic final_flag);
    bit reduce_now;
    if (msg_start) begin
      low_acc   = seed_reg & 32'(HALF_MASK);
      high_acc  = seed_reg >> 16;
      block_pos = '0;
    end
    low_acc  = low_acc + 32'(data);
    high_acc = high_acc + low_acc;
    // Reduce at block boundaries and at the end of a message, never on
    // the opening byte of a message
    reduce_now = !msg_start && (block_pos == '0 || final_flag);
    if (reduce_now) begin
      low_acc  = low_acc % 32'(ADLER_MOD);
      high_acc = high_acc % 32'(ADLER_MOD);
    end
    msg_start = 1'b0;
    if (block_pos == 13'(REDUCE_INTERVAL - 1)) begin
      block_pos = '0;
    end else begin
      block_pos = block_pos + 13'd1;
    end
    if (final_flag) begin
      checksum_q.push_back((high_acc << 16) | low_acc);
      msg_start = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seed_reg       = 32'd1;
      low_acc        = 32'd1;
      high_acc       = 32'd0;
      block_pos      = '0;
      msg_start      = 1'b1;
      mismatch_count = 0;
      checksum_q.delete();
    end else begin
      // Compare a checksum transfer with the oldest prediction
      if (out_valid && !out_stall) begin
        if (checksum_q.size() == 0) begin
          $display("%0t: checksum expected none, got %08h", $time, out_checksum);
          mismatch_count++;
        end else begin
          expected_sum = checksum_q.pop_front();
          if (out_checksum !== expected_sum) begin
            $display("%0t: checksum expected %08h, got %08h", $time, expected_sum,
                     out_checksum);
            mismatch_count++;
          end
        end
      end
      // Advance the sums on a byte transfer
      if (in_valid && !in_stall) begin
        absorb_byte(in_data_byte, in_last_byte);
      end
      // Track the seed; it only takes effect at the next message start
      if (cfg_wr_en) begin
        seed_reg = cfg_wr_data;
      end
    end
    pending_count = checksum_q.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives byte messages and seed writes into the deferred-modulo checksum
// block: directed corner messages, longer messages whose sums grow well past
// 16 bits, then random messages under random source gaps and sink stalls.
// ---------------------------------------------------------------------------
module tb_top;
  import acdm_pkg::*;

  localparam int REDUCE_INTERVAL = 5552;
  localparam int RANDOM_ITEMS    = 850;
  localparam int NUM_PHASES      = 5;
  localparam int IDLE_LIMIT      = 2000;
  localparam int LONG_HOLD       = 150;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 8;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_wr_en    = 1'b0;
  logic [31:0] cfg_wr_data  = '0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_stall    = 1'b0;
  wire         in_stall;
  wire         out_valid;
  wire  [31:0] out_checksum;

  int mismatch_count;
  int pending_count;
  int bytes_sent  = 0;
  int idle_cycles = 0;
  bit quiet_tail  = 1'b0;
  bit hold_req    = 1'b0;

  adler_checksum_deferred_mod_unit #(
    .REDUCE_INTERVAL(REDUCE_INTERVAL)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_checksum(out_checksum)
  );

  acdm_checker #(
    .REDUCE_INTERVAL(REDUCE_INTERVAL)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_checksum  (out_checksum),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  always #4 clk = ~clk;

  // Abort when no transfer happens on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Sink side: random stall bursts, one long hold-off, none in the tail
  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (quiet_tail) begin
        out_stall <= 1'b0;
      end else if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 20)) @(negedge clk);
      end
    end
  end

  // Offer one byte, with an optional gap first; return on its transfer
  task automatic send_byte(input logic [7:0] data, input logic final_flag);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= final_flag;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_message(input int len, input fill_t fill);
    logic [7:0] data;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ONES:  data = 8'hff;
        FILL_ZEROS: data = 8'h00;
        default:    data = 8'($urandom);
      endcase
      send_byte(data, i == len - 1);
    end
  endtask

  // Drop valid, let every checksum drain and the pipeline settle, then
  // write the seed
  task automatic load_seed(input sum_t value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    sum_t  phase_seed[NUM_PHASES];
    int    target;
    int    pick;
    int    len;
    fill_t fill;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset seed: single-byte messages stay unreduced, then a short one
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b1);

    // All-ones seed: widest starting sums
    load_seed(32'hffffffff);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);

    // Zero seed
    load_seed(32'h00000000);
    send_byte(8'h00, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);

    // Seed change inside a message must wait for the next message
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b0);
    load_seed(32'h1234abcd);
    send_byte(8'h3c, 1'b1);
    send_byte(8'hc3, 1'b1);

    // Longer messages: sums grow well past 16 bits before the final reduction
    load_seed(32'hffffffff);
    send_message(160, FILL_ONES);
    send_message(90, FILL_RANDOM);

    // Random messages, one seed per phase; the last phase runs without gaps
    phase_seed = '{32'h00000000, $urandom, 32'hffffffff, $urandom, $urandom};
    for (int p = 0; p < NUM_PHASES; p++) begin
      load_seed(phase_seed[p]);
      if (p == 1) begin
        hold_req = 1'b1;
      end
      if (p == NUM_PHASES - 1) begin
        quiet_tail = 1'b1;
      end
      target = bytes_sent + RANDOM_ITEMS / NUM_PHASES;
      while (bytes_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          len = $urandom_range(1, 8);
        end else if (pick < 93) begin
          len = $urandom_range(9, 40);
        end else begin
          len = $urandom_range(41, 200);
        end
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          fill = FILL_RANDOM;
        end else if (pick < 90) begin
          fill = FILL_ONES;
        end else begin
          fill = FILL_ZEROS;
        end
        send_message(len, fill);
      end
    end

    // Drain and give the verdict
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: adler_checksum_deferred_mod_unit.f
rtl/acdm_pkg.sv
rtl/adler_checksum_deferred_mod_unit.sv
test/acdm_checker.sv
test/tb_top.sv
